// File: design/csrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csrs_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    localparam int OP_W     = 3;
    localparam int KEY_W    = 16;
    localparam int SIZE_W   = 40;
    localparam int NPOS_W   = 49;
    localparam int POS_W    = 48;
    localparam int COUNT_W  = 32;
    localparam int SEG_W    = 4;
    localparam int STAT_W   = 2;
    localparam int ENTRY_W  = SIZE_W + KEY_W + 1;
    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 144;

    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
    localparam logic [OP_W-1:0] OP_FLAGS = 3'd2;
    localparam logic [OP_W-1:0] OP_SEEK  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FAIL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SF_ADDR,
        ST_SF_CHECK,
        ST_RD_ADDR,
        ST_RD_FIND,
        ST_RD_NEXT,
        ST_RD_CHUNK,
        ST_RD_CLOSE
    } state_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               chunk_valid;
        logic [SEG_W-1:0]   segment;
        logic [SIZE_W-1:0]  offset;
        logic [COUNT_W-1:0] length;
        logic [COUNT_W-1:0] buf_offset;
        logic               unavailable;
        logic [COUNT_W-1:0] bytes_read;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

// File: design/concatenated_segment_read_splitter.sv
`timescale 1ns / 1ps
`default_nettype none

// One request in work at a time. Add, clear, seek and unused ops give one result; set flags
// compares the entries in turn until a key matches; read scans the entries for the position,
// then gives one result per chunk and a closing result, stopping at an empty or unavailable
// chunk or when no entry holds the position. m_tready stalls can delay each result. The next
// request is taken once the last result of the one in work is registered.
// Reset (rst_n low, async) empties the table, zeroes length and position; RAM keeps data.
module concatenated_segment_read_splitter (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // seg_key, seg_size, seg_available, new_position, byte_count, zero pad
    input  wire  [csrs_pkg::S_DATA_W-1:0]    s_tdata,
    // op
    input  wire  [csrs_pkg::OP_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // op_status, chunk_segment, chunk_offset, chunk_length, buffer_offset,
    // unavailable, bytes_read, zero pad
    output logic [csrs_pkg::M_DATA_W-1:0]    m_tdata,
    // chunk_valid
    output logic                             m_tuser,
    output logic                             m_tlast
);

    import csrs_pkg::*;

    state_t state_reg, state_next;

    logic [OP_W-1:0]    op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic               avail_reg;
    logic [NPOS_W-1:0]  npos_reg;
    logic [COUNT_W-1:0] bcount_reg;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]   total_reg, total_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic [CNT_W-1:0]   k_reg, k_next;
    logic [POS_W-1:0]   base_reg, base_next;
    logic [SIZE_W-1:0]  offset_reg, offset_next;
    logic [COUNT_W-1:0] done_reg, done_next;
    logic [STAT_W-1:0]  rd_stat_reg, rd_stat_next;
    logic               rd_unav_reg, rd_unav_next;

    logic               m_valid_reg, m_valid_next;
    res_t               res_reg, res_next;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic               accept, slot_free, k_done;
    logic [SIZE_W-1:0]  ent_size;
    logic [KEY_W-1:0]   ent_key;
    logic               ent_avail, key_match, find_hit;
    logic [POS_W:0]     find_sum;
    logic [COUNT_W-1:0] want, chunk_len;
    logic [SIZE_W-1:0]  left;
    logic               len_zero;

    csrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (k_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign k_done    = (k_reg >= count_reg);

    assign ent_size  = ram_rdata[SIZE_W-1:0];
    assign ent_key   = ram_rdata[SIZE_W +: KEY_W];
    assign ent_avail = ram_rdata[ENTRY_W-1];
    assign key_match = (ent_key == key_reg);

    assign find_sum  = {1'b0, base_reg} + (POS_W+1)'(ent_size);
    assign find_hit  = (find_sum > {1'b0, pos_reg});

    // chunk length: min of bytes still wanted and bytes left in the segment
    assign want      = bcount_reg - done_reg;
    assign left      = ent_size - offset_reg;
    assign chunk_len = (SIZE_W'(want) < left) ? want : left[COUNT_W-1:0];
    assign len_zero  = (chunk_len == '0);

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.chunk_valid;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {1'b0, res_reg.bytes_read, res_reg.unavailable, res_reg.buf_offset,
                       res_reg.length, res_reg.offset, res_reg.segment, res_reg.status};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == OP_FLAGS)
                        state_next = ST_SF_ADDR;
                    else if (s_tuser == OP_READ)
                        state_next = ST_RD_ADDR;
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            ST_SF_ADDR:
            begin
                if (!k_done)
                    state_next = ST_SF_CHECK;
                else if (slot_free)
                    state_next = ST_IDLE;
            end
            ST_SF_CHECK:
            begin
                if (!key_match)
                    state_next = ST_SF_ADDR;
                else if (slot_free)
                    state_next = ST_IDLE;
            end
            ST_RD_ADDR:
                state_next = k_done ? ST_RD_CLOSE : ST_RD_FIND;
            ST_RD_FIND:
                state_next = find_hit ? ST_RD_CHUNK : ST_RD_ADDR;
            ST_RD_NEXT:
                state_next = k_done ? ST_RD_CLOSE : ST_RD_CHUNK;
            ST_RD_CHUNK:
            begin
                if (len_zero || !ent_avail)
                    state_next = ST_RD_CLOSE;
                else if (slot_free)
                    state_next = ST_RD_NEXT;
            end
            ST_RD_CLOSE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        res_t r;
        logic emit;

        count_next   = count_reg;
        total_next   = total_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        base_next    = base_reg;
        offset_next  = offset_reg;
        done_next    = done_reg;
        rd_stat_next = rd_stat_reg;
        rd_unav_next = rd_unav_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = k_reg[IDX_W-1:0];
        ram_wdata    = {avail_reg, ent_key, ent_size};
        emit         = 1'b0;
        r            = '0;
        r.last       = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    k_next       = '0;
                    base_next    = '0;
                    offset_next  = '0;
                    done_next    = '0;
                    rd_stat_next = STAT_OK;
                    rd_unav_next = 1'b0;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    unique case (op_reg)
                        OP_ADD:
                        begin
                            if (size_reg == '0)
                                r.status = STAT_FAIL;
                            else if (count_reg >= CNT_W'(MAX_SEGMENTS))
                                r.status = STAT_FULL;
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[IDX_W-1:0];
                                ram_wdata  = {avail_reg, key_reg, size_reg};
                                count_next = count_reg + 1'b1;
                                total_next = total_reg + POS_W'(size_reg);
                                r.status   = STAT_OK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                            pos_next   = '0;
                            r.status   = STAT_OK;
                        end
                        OP_SEEK:
                        begin
                            if (!npos_reg[NPOS_W-1] && (npos_reg[POS_W-1:0] <= total_reg))
                            begin
                                pos_next = npos_reg[POS_W-1:0];
                                r.status = STAT_OK;
                            end
                            else
                                r.status = STAT_FAIL;
                        end
                        default:
                            r.status = STAT_FAIL;
                    endcase
                end
            end
            ST_SF_ADDR:
            begin
                if (!k_done)
                    ram_re = 1'b1;
                else if (slot_free)
                begin
                    emit     = 1'b1;
                    r.status = STAT_FAIL;
                end
            end
            ST_SF_CHECK:
            begin
                if (!key_match)
                    k_next = k_reg + 1'b1;
                else if (slot_free)
                begin
                    ram_we   = 1'b1;
                    emit     = 1'b1;
                    r.status = STAT_OK;
                end
            end
            ST_RD_ADDR:
            begin
                if (!k_done)
                    ram_re = 1'b1;
            end
            ST_RD_FIND:
            begin
                if (find_hit)
                    offset_next = SIZE_W'(pos_reg - base_reg);
                else
                begin
                    base_next = find_sum[POS_W-1:0];
                    k_next    = k_reg + 1'b1;
                end
            end
            ST_RD_NEXT:
            begin
                if (!k_done)
                    ram_re = 1'b1;
            end
            ST_RD_CHUNK:
            begin
                if (len_zero)
                begin
                    // nothing left to deliver: close with what we have
                end
                else if (!ent_avail)
                begin
                    rd_stat_next = STAT_FAIL;
                    rd_unav_next = 1'b1;
                end
                else if (slot_free)
                begin
                    emit          = 1'b1;
                    r.status      = STAT_OK;
                    r.chunk_valid = 1'b1;
                    r.segment     = SEG_W'(k_reg);
                    r.offset      = offset_reg;
                    r.length      = chunk_len;
                    r.buf_offset  = done_reg;
                    r.bytes_read  = done_reg + chunk_len;
                    r.last        = 1'b0;
                    done_next     = done_reg + chunk_len;
                    offset_next   = '0;
                    k_next        = k_reg + 1'b1;
                end
            end
            ST_RD_CLOSE:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    r.status      = rd_stat_reg;
                    r.unavailable = rd_unav_reg;
                    r.bytes_read  = done_reg;
                    pos_next      = pos_reg + POS_W'(done_reg);
                end
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            m_valid_next = 1'b1;
            res_next     = r;
        end
        else
        begin
            m_valid_next = m_valid_reg && !m_tready;
            res_next     = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_tuser;
            key_reg    <= s_tdata[15:0];
            size_reg   <= s_tdata[55:16];
            avail_reg  <= s_tdata[56];
            npos_reg   <= s_tdata[105:57];
            bcount_reg <= s_tdata[137:106];
        end
        k_reg       <= k_next;
        base_reg    <= base_next;
        offset_reg  <= offset_next;
        done_reg    <= done_next;
        rd_stat_reg <= rd_stat_next;
        rd_unav_reg <= rd_unav_next;
        res_reg     <= res_next;
    end

endmodule

`default_nettype wire

// File: design/csrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module csrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                            clk,
    input  wire                                            we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  wire  [WIDTH-1:0]                               wdata,
    input  wire                                            re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: bench/segment_stream_tb_pkg.sv
`timescale 1ns / 1ps

package segment_stream_tb_pkg;

    import csrs_pkg::*;

    // Mirrors the segment table and stream position, turns each request into
    // the results it should produce, and checks what comes out of the block.
    class segment_stream_checker;

        logic [SIZE_W-1:0] seg_sizes [MAX_SEGMENTS];
        logic [KEY_W-1:0]  seg_keys  [MAX_SEGMENTS];
        logic              seg_avail [MAX_SEGMENTS];
        int                seg_count;
        logic [POS_W-1:0]  total_len;
        logic [POS_W-1:0]  position;

        res_t expected_results [$];

        int errors;
        int n_requests;
        int n_results;
        int n_chunks;
        int n_unavail_stops;
        int n_full_refusals;

        function new();
            seg_count       = 0;
            total_len       = '0;
            position        = '0;
            errors          = 0;
            n_requests      = 0;
            n_results       = 0;
            n_chunks        = 0;
            n_unavail_stops = 0;
            n_full_refusals = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                   input logic [SIZE_W-1:0] size, input logic avail,
                                   input logic [NPOS_W-1:0] npos,
                                   input logic [COUNT_W-1:0] count);
            res_t r;
            int k;
            bit found;
            bit stop;
            longint unsigned base;
            longint unsigned offset;
            longint unsigned delivered;
            longint unsigned want;
            longint unsigned left;
            longint unsigned len;

            n_requests++;
            r = '0;
            r.last = 1'b1;
            case (op)
                OP_ADD:
                begin
                    if (size == '0)
                        r.status = STAT_FAIL;
                    else if (seg_count >= MAX_SEGMENTS)
                    begin
                        r.status = STAT_FULL;
                        n_full_refusals++;
                    end
                    else
                    begin
                        seg_sizes[seg_count] = size;
                        seg_keys[seg_count]  = key;
                        seg_avail[seg_count] = avail;
                        seg_count++;
                        total_len = total_len + POS_W'(size);
                        r.status = STAT_OK;
                    end
                    expected_results.push_back(r);
                end
                OP_CLEAR:
                begin
                    seg_count = 0;
                    total_len = '0;
                    position  = '0;
                    r.status  = STAT_OK;
                    expected_results.push_back(r);
                end
                OP_FLAGS:
                begin
                    // only the lowest matching entry changes
                    found = 1'b0;
                    k = 0;
                    while (k < seg_count && !found)
                    begin
                        if (seg_keys[k] == key)
                        begin
                            seg_avail[k] = avail;
                            found = 1'b1;
                        end
                        k++;
                    end
                    r.status = found ? STAT_OK : STAT_FAIL;
                    expected_results.push_back(r);
                end
                OP_SEEK:
                begin
                    r.status = STAT_FAIL;
                    if (!npos[NPOS_W-1] && npos[POS_W-1:0] <= total_len)
                    begin
                        position = npos[POS_W-1:0];
                        r.status = STAT_OK;
                    end
                    expected_results.push_back(r);
                end
                OP_READ:
                begin
                    base = 0;
                    offset = 0;
                    delivered = 0;
                    k = 0;
                    while (k < seg_count && base + seg_sizes[k] <= position)
                    begin
                        base += seg_sizes[k];
                        k++;
                    end
                    if (k < seg_count)
                        offset = position - base;
                    stop = 1'b0;
                    while (k < seg_count && !stop)
                    begin
                        want = count - delivered;
                        left = seg_sizes[k] - offset;
                        len  = (want < left) ? want : left;
                        if (len == 0)
                            stop = 1'b1;
                        else if (!seg_avail[k])
                        begin
                            r.status = STAT_FAIL;
                            r.unavailable = 1'b1;
                            n_unavail_stops++;
                            stop = 1'b1;
                        end
                        else
                        begin
                            res_t c;
                            c = '0;
                            c.status      = STAT_OK;
                            c.chunk_valid = 1'b1;
                            c.segment     = SEG_W'(k);
                            c.offset      = SIZE_W'(offset);
                            c.length      = COUNT_W'(len);
                            c.buf_offset  = COUNT_W'(delivered);
                            c.bytes_read  = COUNT_W'(delivered + len);
                            expected_results.push_back(c);
                            delivered += len;
                            offset = 0;
                            k++;
                        end
                    end
                    position = position + POS_W'(delivered);
                    r.bytes_read = COUNT_W'(delivered);
                    expected_results.push_back(r);
                end
                default:
                begin
                    r.status = STAT_FAIL;
                    expected_results.push_back(r);
                end
            endcase
        endfunction

        function void compare_field(input string name, input longint unsigned exp_val,
                                    input longint unsigned act_val);
            if (exp_val != act_val)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(input logic [M_DATA_W-1:0] data, input logic user,
                                   input logic lastbit);
            res_t want;
            logic [M_DATA_W-1:0] d;

            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: tdata 0x%0h", data);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            n_results++;
            if (user)
                n_chunks++;
            d = data;
            compare_field("op_status", want.status, d[STAT_W-1:0]);
            d = d >> STAT_W;
            compare_field("chunk_segment", want.segment, d[SEG_W-1:0]);
            d = d >> SEG_W;
            compare_field("chunk_offset", want.offset, d[SIZE_W-1:0]);
            d = d >> SIZE_W;
            compare_field("chunk_length", want.length, d[COUNT_W-1:0]);
            d = d >> COUNT_W;
            compare_field("buffer_offset", want.buf_offset, d[COUNT_W-1:0]);
            d = d >> COUNT_W;
            compare_field("unavailable", want.unavailable, d[0]);
            d = d >> 1;
            compare_field("bytes_read", want.bytes_read, d[COUNT_W-1:0]);
            compare_field("chunk_valid", want.chunk_valid, user);
            compare_field("last", want.last, lastbit);
        endfunction

    endclass

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import csrs_pkg::*;
    import segment_stream_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_REQUESTS = 300;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]     s_tuser  = '0;
    logic                m_tready = 1'b0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire [M_DATA_W-1:0]  m_tdata;
    wire                 m_tuser;
    wire                 m_tlast;

    segment_stream_checker stream_model = new();

    logic [KEY_W-1:0] key_pool [$];
    bit steady_sender   = 1'b0;
    bit steady_receiver = 1'b0;
    int cycles = 0;

    concatenated_segment_read_splitter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, stream_model.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            stream_model.check_result(m_tdata, m_tuser, m_tlast);
    end

    // mostly short gaps, a few long ones, none at all in steady stretches
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = pick_gap(steady_receiver);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [SIZE_W-1:0] size, input logic avail,
                                input logic [NPOS_W-1:0] npos,
                                input logic [COUNT_W-1:0] count);
        int gap;
        logic [S_DATA_W-1:0] payload;
        gap = pick_gap(steady_sender);
        payload = '0;
        payload[S_DATA_W-7:0] = {count, npos, avail, size, key};
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= payload;
        do
            @(posedge clk);
        while (!s_tready);
        stream_model.note_request(op, key, size, avail, npos, count);
    endtask

    // hold the sender off until the block has delivered everything
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (stream_model.pending() != 0);
    endtask

    task automatic send_random_add();
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            size = '0;
        else if (r < 3)
            size = SIZE_W'({$urandom, $urandom});
        else
            size = SIZE_W'($urandom_range(1, 40));
        if (key_pool.size() != 0 && $urandom_range(0, 2) == 0)
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
            key = KEY_W'($urandom);
        key_pool.push_back(key);
        send_request(OP_ADD, key, size, ($urandom_range(0, 3) != 0),
                     NPOS_W'({$urandom, $urandom}), $urandom);
    endtask

    initial
    begin
        int nseg;
        int pick;
        bit first_phase;
        logic [KEY_W-1:0]   rk;
        logic [SIZE_W-1:0]  rs;
        logic               ra;
        logic [NPOS_W-1:0]  rn;
        logic [COUNT_W-1:0] rc;
        longint unsigned    span;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicate keys, unavailable stop
        send_request(OP_READ, '0, '0, 1'b0, '0, 32'd10);
        send_request(OP_ADD, 16'h0000, '0, 1'b1, '0, '0);
        send_request(OP_ADD, 16'hFFFF, SIZE_MAX, 1'b1, '0, '0);
        send_request(OP_ADD, 16'h1234, 40'd5, 1'b0, '0, '0);
        send_request(OP_ADD, 16'h1234, 40'd7, 1'b1, '0, '0);
        send_request(OP_ADD, 16'h00AA, 40'd3, 1'b1, '0, '0);
        send_request(OP_SEEK, '0, '0, 1'b0, '1, '0);
        send_request(OP_SEEK, '0, '0, 1'b0, NPOS_W'(stream_model.total_len) + 1'b1, '0);
        send_request(OP_SEEK, '0, '0, 1'b0, NPOS_W'(stream_model.total_len), '0);
        send_request(OP_READ, '0, '0, 1'b0, '0, 32'd100);
        send_request(OP_SEEK, '0, '0, 1'b0, '0, '0);
        send_request(OP_READ, '0, '0, 1'b0, '0, '0);
        send_request(OP_READ, '0, '0, 1'b0, '0, '1);
        send_request(OP_SEEK, '0, '0, 1'b0, NPOS_W'(SIZE_MAX - 2), '0);
        send_request(OP_READ, '0, '0, 1'b0, '0, '1);
        send_request(OP_FLAGS, 16'h1234, '0, 1'b1, '0, '0);
        send_request(OP_READ, '0, '0, 1'b0, '0, '1);
        send_request(OP_FLAGS, 16'h5555, '0, 1'b1, '0, '0);
        for (int u = OP_READ + 1; u < (1 << OP_W); u++)
            send_request(OP_W'(u), KEY_W'($urandom), SIZE_W'({$urandom, $urandom}), 1'b1,
                         NPOS_W'({$urandom, $urandom}), $urandom);
        send_request(OP_CLEAR, '0, '0, 1'b0, '0, '0);
        send_request(OP_READ, '0, '0, 1'b0, '0, 32'd5);

        // random: build a table, then work on it
        first_phase = 1'b1;
        while (stream_model.n_requests < RANDOM_REQUESTS)
        begin
            steady_sender   = ($urandom_range(0, 4) == 0);
            steady_receiver = ($urandom_range(0, 4) == 0);
            if (first_phase || $urandom_range(0, 2) == 0)
                wait_drained();
            first_phase = 1'b0;
            if ($urandom_range(0, 3) != 0)
            begin
                send_request(OP_CLEAR, KEY_W'($urandom), SIZE_W'({$urandom, $urandom}), 1'b1,
                             NPOS_W'({$urandom, $urandom}), $urandom);
                key_pool.delete();
            end
            if ($urandom_range(0, 5) == 0)
                nseg = $urandom_range(MAX_SEGMENTS - 2, MAX_SEGMENTS + 2);
            else
                nseg = $urandom_range(1, 6);
            repeat (nseg) send_random_add();

            repeat ($urandom_range(6, 16))
            begin
                rk = KEY_W'($urandom);
                rs = SIZE_W'({$urandom, $urandom});
                ra = 1'($urandom_range(0, 1));
                rn = NPOS_W'({$urandom, $urandom});
                rc = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    if ($urandom_range(0, 7) != 0)
                        rc = $urandom_range(0, 60);
                    send_request(OP_READ, rk, rs, ra, rn, rc);
                end
                else if (pick < 65)
                begin
                    span = longint'(stream_model.total_len) + 1;
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        rn = NPOS_W'({$urandom, $urandom} % span);
                    else if (pick == 7)
                        rn = NPOS_W'(stream_model.total_len);
                    else if (pick == 8)
                        rn[NPOS_W-1] = 1'b1;
                    else
                        rn = NPOS_W'(span + ({$urandom, $urandom} & 64'h3FFF_FFFF_FFFF));
                    send_request(OP_SEEK, rk, rs, ra, rn, rc);
                end
                else if (pick < 80)
                begin
                    if (key_pool.size() != 0 && $urandom_range(0, 4) != 0)
                        rk = key_pool[$urandom_range(0, key_pool.size() - 1)];
                    send_request(OP_FLAGS, rk, rs, ra, rn, rc);
                end
                else if (pick < 90)
                    send_random_add();
                else if (pick < 95)
                begin
                    send_request(OP_CLEAR, rk, rs, ra, rn, rc);
                    key_pool.delete();
                end
                else
                    send_request(OP_W'($urandom_range(OP_READ + 1, (1 << OP_W) - 1)),
                                 rk, rs, ra, rn, rc);
            end
        end

        s_tvalid <= 1'b0;
        while (stream_model.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("%0d requests gave %0d results, %0d of them read chunks",
                 stream_model.n_requests, stream_model.n_results, stream_model.n_chunks);
        $display("reads stopped on unavailable segments: %0d, adds refused on a full table: %0d",
                 stream_model.n_unavail_stops, stream_model.n_full_refusals);
        if (stream_model.errors == 0 && stream_model.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
